// ----- rtl/core/hjg_pkg.sv -----
// Shared definitions for the Halton jitter generator: field widths, register
// indexes, reset values, sequencer states and the divide-by-three constants.
// No dependencies.
`default_nettype none

package hjg_pkg;

    // Default values of the top-level parameters.
    localparam int MAX_PHASES_DEF       = 256;
    localparam int JITTER_FRAC_BITS_DEF = 16;
    localparam int CLIP_FRAC_BITS_DEF   = 24;

    // Default widths of the shared divider at the default parameters.
    localparam int DIVIDEND_W_DEF = 25;
    localparam int DIVISOR_W_DEF  = 15;

    // Configuration register widths and indexes.
    localparam int PC_W      = 9;
    localparam int VP_W      = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_HEIGHT = 2'd2;

    localparam logic [PC_W-1:0] PHASE_COUNT_RST     = 9'd16;
    localparam logic [VP_W-1:0] VIEWPORT_WIDTH_RST  = 15'd1920;
    localparam logic [VP_W-1:0] VIEWPORT_HEIGHT_RST = 15'd1080;

    // n / 3 == (n * RECIP3) >> RECIP3_SH for every n below 98304.
    localparam int RECIP3    = 43691;
    localparam int RECIP3_SH = 17;

    // Input beat width: the restart flag sits alone in bit 0.
    localparam int IN_W = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_DIGITS,
        ST_JIT_X,
        ST_JIT_Y,
        ST_CLIP_X,
        ST_CLIP_Y,
        ST_PUSH
    } hjg_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/hjg_divider.sv -----
// Restoring unsigned divider, one quotient bit per cycle, shared by the modulo,
// jitter and clip divisions in the jitter generator. Uses hjg_pkg for its default widths.
`default_nettype none

module hjg_divider
    import hjg_pkg::*;
#(
    parameter int DIVIDEND_W = DIVIDEND_W_DEF,
    parameter int DIVISOR_W  = DIVISOR_W_DEF,
    localparam int IT_W      = $clog2(DIVIDEND_W + 1)
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [IT_W-1:0]       iters,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       busy,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient,
    output logic [DIVISOR_W-1:0]       remainder
);

    logic [DIVIDEND_W-1:0] dq_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [IT_W-1:0]       cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_sub;
    logic                  take;
    logic [DIVISOR_W-1:0]  rem_next;

    // The dividend arrives left-aligned, so only iters steps are needed.
    always_comb begin
        rem_sh   = {rem_reg, dq_reg[DIVIDEND_W-1]};
        rem_sub  = rem_sh - {1'b0, dvs_reg};
        take     = (rem_sh >= {1'b0, dvs_reg});
        rem_next = take ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= iters;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == IT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dq_reg  <= {dq_reg[DIVIDEND_W-2:0], take};
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/core/halton_jitter_generator_unit.sv -----
// Top level of the Halton (base 2 and 3) subpixel jitter generator: phase
// sequencer, digit loops and clip scaling. Uses hjg_pkg and hjg_divider.
//
//   channel | ports                         | beat contents
//   --------+-------------------------------+------------------------------------
//   input   | s_tvalid s_tready s_tdata     | restart flag
//   result  | m_tvalid m_tready m_tdata     | phase, jitter x/y, clip x/y
//   config  | cfg_wr_en cfg_addr cfg_wdata  | phase_count, viewport width/height
//
// An advancing beat runs the modulo division, the base-2 and base-3 digit loops
// (side by side until both finish), the x and y jitter divisions, the x and y
// clip divisions and the push into the output register, in that order. Five
// divisions run back to back through the shared bit-serial divider. A restart
// beat or a beat with phase count zero is taken in ST_IDLE and starts no
// sequence. Reset is synchronous and needs no clearing pass. A finished result
// waits in the output register, and the next beat is accepted meanwhile; it
// then waits for that register to free.
`default_nettype none

module halton_jitter_generator_unit
    import hjg_pkg::*;
#(
    parameter int MAX_PHASES       = MAX_PHASES_DEF,
    parameter int JITTER_FRAC_BITS = JITTER_FRAC_BITS_DEF,
    parameter int CLIP_FRAC_BITS   = CLIP_FRAC_BITS_DEF,
    localparam int PH_W     = $clog2(MAX_PHASES),
    localparam int CW       = CLIP_FRAC_BITS + 1,
    localparam int OUT_BITS = PH_W + 2 * JITTER_FRAC_BITS + 2 * CW,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_W-1:0]      s_tdata,   // [0] restart
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_W-1:0]          m_tdata,   // phase, jitter_x, jitter_y, clip_x, clip_y
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [CFG_DAT_W-1:0] cfg_wdata
);

    localparam int JF     = JITTER_FRAC_BITS;
    localparam int NW     = PH_W + 1;
    localparam int CNT_W  = (PC_W > NW) ? PC_W : NW;
    localparam int DEN_W  = $clog2(3 * MAX_PHASES + 1);
    localparam int JD_W   = DEN_W + JF - 1;
    localparam int CL_SH  = (CLIP_FRAC_BITS + 1 >= JF) ? CLIP_FRAC_BITS + 1 - JF : 0;
    localparam int CD_SH  = (CLIP_FRAC_BITS + 1 >= JF) ? 0 : JF - CLIP_FRAC_BITS - 1;
    localparam int CD_W   = JF + CL_SH;
    localparam int SZ_W   = VP_W + CD_SH;
    localparam int DIV_A  = (JD_W > CD_W) ? JD_W : CD_W;
    localparam int DIV_W  = (DIV_A > NW) ? DIV_A : NW;
    localparam int DVS_A  = (DEN_W > SZ_W) ? DEN_W : SZ_W;
    localparam int DVS_W  = (DVS_A > CNT_W) ? DVS_A : CNT_W;
    localparam int IT_W   = $clog2(DIV_W + 1);
    localparam int P3_W   = NW + RECIP3_SH;
    localparam int MOD_LS = DIV_W - NW;
    localparam int JIT_LS = DIV_W - DEN_W;
    localparam int CLP_LS = DIV_W - JF;

    // Configuration registers.
    logic [PC_W-1:0] phase_count_reg;
    logic [VP_W-1:0] viewport_width_reg;
    logic [VP_W-1:0] viewport_height_reg;

    // Sequencer and working registers.
    hjg_state_t state_reg, state_next;
    logic [PH_W-1:0]         idx_reg;
    logic [NW-1:0]           n2_reg, n3_reg;
    logic [DEN_W-1:0]        num2_reg, den2_reg, num3_reg, den3_reg;
    logic signed [JF-1:0]    jx_reg, jy_reg;
    logic signed [CW-1:0]    cx_reg, cy_reg;

    // Output register.
    logic                    m_valid_reg;
    logic [PH_W-1:0]         o_phase_reg;
    logic signed [JF-1:0]    o_jx_reg, o_jy_reg;
    logic signed [CW-1:0]    o_cx_reg, o_cy_reg;

    // Divider interface.
    logic                    div_start, div_busy, div_done;
    logic [IT_W-1:0]         div_iters;
    logic [DIV_W-1:0]        div_dividend, div_quo;
    logic [DVS_W-1:0]        div_divisor, div_rem;

    logic                    accept, restart, push;
    logic [CNT_W-1:0]        count_ext, count;
    logic [NW-1:0]           idx_inc, n_new;
    logic [VP_W-1:0]         wsize, hsize;

    logic [DEN_W+1:0]        a2, a3;
    logic                    neg2, neg3;
    logic [DEN_W-1:0]        mag2, mag3;
    logic [JF-1:0]           absx, absy;

    logic [P3_W-1:0]         prod3;
    logic [NW-1:0]           q3;
    logic [1:0]              digit3;
    logic [DEN_W+1:0]        num3_x3, den3_x3;

    logic                    jneg;
    logic [JF-1:0]           qj;
    logic [JF-1:0]           jit_val;
    logic                    cneg;
    logic [CW-1:0]           qc;
    logic [CW-1:0]           clip_val;

    hjg_divider #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (DVS_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .iters     (div_iters),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // ---------------------------------------------------------------------
    // Shared arithmetic around the divider.
    // ---------------------------------------------------------------------
    always_comb begin
        restart   = s_tdata[0];
        count_ext = CNT_W'(phase_count_reg);
        count     = (count_ext > CNT_W'(MAX_PHASES)) ? CNT_W'(MAX_PHASES) : count_ext;
        idx_inc   = NW'(idx_reg) + NW'(1);
        n_new     = NW'(div_rem[PH_W-1:0]) + NW'(1);
        wsize     = (viewport_width_reg == '0) ? VP_W'(1) : viewport_width_reg;
        hsize     = (viewport_height_reg == '0) ? VP_W'(1) : viewport_height_reg;

        // Twice the radical inverse minus one, scaled by the denominator.
        a2   = (DEN_W + 2)'({num2_reg, 1'b0}) - (DEN_W + 2)'(den2_reg);
        a3   = (DEN_W + 2)'({num3_reg, 1'b0}) - (DEN_W + 2)'(den3_reg);
        neg2 = a2[DEN_W+1];
        neg3 = a3[DEN_W+1];
        mag2 = neg2 ? DEN_W'(-a2) : a2[DEN_W-1:0];
        mag3 = neg3 ? DEN_W'(-a3) : a3[DEN_W-1:0];
        absx = jx_reg[JF-1] ? $unsigned(-jx_reg) : $unsigned(jx_reg);
        absy = jy_reg[JF-1] ? $unsigned(-jy_reg) : $unsigned(jy_reg);

        // One base-3 digit per cycle.
        prod3   = P3_W'(n3_reg) * P3_W'(RECIP3);
        q3      = prod3[RECIP3_SH +: NW];
        digit3  = 2'(n3_reg - q3 - {q3[NW-2:0], 1'b0});
        num3_x3 = (DEN_W + 2)'(num3_reg) + (DEN_W + 2)'({num3_reg, 1'b0})
                  + (DEN_W + 2)'(digit3);
        den3_x3 = (DEN_W + 2)'(den3_reg) + (DEN_W + 2)'({den3_reg, 1'b0});

        // Floor for a negative jitter: -(q+1) is ~q, -q is ~q + 1.
        jneg    = (state_reg == ST_JIT_X) ? neg2 : neg3;
        qj      = div_quo[JF-1:0];
        jit_val = jneg ? (~qj + JF'(div_rem == '0)) : qj;

        // Clip offset truncates toward zero and saturates at the top.
        cneg     = (state_reg == ST_CLIP_X) ? jx_reg[JF-1] : jy_reg[JF-1];
        qc       = div_quo[CW-1:0];
        clip_val = cneg ? -qc : (qc[CW-1] ? {1'b0, {(CW - 1){1'b1}}} : qc);
    end

    // ---------------------------------------------------------------------
    // Sequencer: next state.
    // ---------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && !restart && (count != '0)) begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD: begin
                if (div_done) begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS: begin
                if ((n2_reg == '0) && (n3_reg == '0)) begin
                    state_next = ST_JIT_X;
                end
            end
            ST_JIT_X: begin
                if (div_done) begin
                    state_next = ST_JIT_Y;
                end
            end
            ST_JIT_Y: begin
                if (div_done) begin
                    state_next = ST_CLIP_X;
                end
            end
            ST_CLIP_X: begin
                if (div_done) begin
                    state_next = ST_CLIP_Y;
                end
            end
            ST_CLIP_Y: begin
                if (div_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer: outputs and divider operands.
    // ---------------------------------------------------------------------
    always_comb begin
        s_tready     = 1'b0;
        push         = 1'b0;
        div_start    = 1'b0;
        div_iters    = IT_W'(NW);
        div_dividend = DIV_W'(idx_inc) << MOD_LS;
        div_divisor  = DVS_W'(count);
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_MOD: begin
                div_start = !div_busy && !div_done;
            end
            ST_JIT_X: begin
                div_start    = !div_busy && !div_done;
                div_iters    = IT_W'(JD_W);
                div_dividend = DIV_W'(mag2) << JIT_LS;
                div_divisor  = DVS_W'(den2_reg);
            end
            ST_JIT_Y: begin
                div_start    = !div_busy && !div_done;
                div_iters    = IT_W'(JD_W);
                div_dividend = DIV_W'(mag3) << JIT_LS;
                div_divisor  = DVS_W'(den3_reg);
            end
            ST_CLIP_X: begin
                div_start    = !div_busy && !div_done;
                div_iters    = IT_W'(CD_W);
                div_dividend = DIV_W'(absx) << CLP_LS;
                div_divisor  = DVS_W'(wsize) << CD_SH;
            end
            ST_CLIP_Y: begin
                div_start    = !div_busy && !div_done;
                div_iters    = IT_W'(CD_W);
                div_dividend = DIV_W'(absy) << CLP_LS;
                div_divisor  = DVS_W'(hsize) << CD_SH;
            end
            ST_PUSH: begin
                push = !m_valid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // ---------------------------------------------------------------------
    // Control registers.
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            idx_reg             <= '0;
            m_valid_reg         <= 1'b0;
            phase_count_reg     <= PHASE_COUNT_RST;
            viewport_width_reg  <= VIEWPORT_WIDTH_RST;
            viewport_height_reg <= VIEWPORT_HEIGHT_RST;
        end else begin
            state_reg <= state_next;
            if (accept && restart) begin
                idx_reg <= '0;
            end else if ((state_reg == ST_MOD) && div_done) begin
                idx_reg <= div_rem[PH_W-1:0];
            end
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_PHASE_COUNT:     phase_count_reg     <= cfg_wdata[PC_W-1:0];
                    CFG_VIEWPORT_WIDTH:  viewport_width_reg  <= cfg_wdata[VP_W-1:0];
                    CFG_VIEWPORT_HEIGHT: viewport_height_reg <= cfg_wdata[VP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // Datapath registers.
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_MOD: begin
                if (div_done) begin
                    n2_reg   <= n_new;
                    n3_reg   <= n_new;
                    num2_reg <= '0;
                    num3_reg <= '0;
                    den2_reg <= DEN_W'(1);
                    den3_reg <= DEN_W'(1);
                end
            end
            ST_DIGITS: begin
                if (n2_reg != '0) begin
                    num2_reg <= {num2_reg[DEN_W-2:0], n2_reg[0]};
                    den2_reg <= {den2_reg[DEN_W-2:0], 1'b0};
                    n2_reg   <= n2_reg >> 1;
                end
                if (n3_reg != '0) begin
                    num3_reg <= num3_x3[DEN_W-1:0];
                    den3_reg <= den3_x3[DEN_W-1:0];
                    n3_reg   <= q3;
                end
            end
            ST_JIT_X: begin
                if (div_done) begin
                    jx_reg <= $signed(jit_val);
                end
            end
            ST_JIT_Y: begin
                if (div_done) begin
                    jy_reg <= $signed(jit_val);
                end
            end
            ST_CLIP_X: begin
                if (div_done) begin
                    cx_reg <= $signed(clip_val);
                end
            end
            ST_CLIP_Y: begin
                if (div_done) begin
                    cy_reg <= $signed(clip_val);
                end
            end
            default: ;
        endcase
        if (push) begin
            o_phase_reg <= idx_reg;
            o_jx_reg    <= jx_reg;
            o_jy_reg    <= jy_reg;
            o_cx_reg    <= cx_reg;
            o_cy_reg    <= cy_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({o_cy_reg, o_cx_reg, o_jy_reg, o_jx_reg, o_phase_reg});

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    a_phase_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (CNT_W'(o_phase_reg) < count))
        else $error("result phase is not below the phase count");

    a_den2_power: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_JIT_X) |-> $onehot(den2_reg))
        else $error("base-2 denominator is not a power of two");

    a_fraction: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_JIT_X) |-> ((num2_reg < den2_reg) && (num3_reg < den3_reg)))
        else $error("radical inverse is not below one");

    a_done_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> ((state_reg == ST_MOD) || (state_reg == ST_JIT_X) ||
                      (state_reg == ST_JIT_Y) || (state_reg == ST_CLIP_X) ||
                      (state_reg == ST_CLIP_Y)))
        else $error("divider finished outside a division step");

endmodule

`default_nettype wire
